@@ sv/fp_pkg.sv @@
// Types, codes and constants shared by the frame pacer modules.
package fp_pkg;

  localparam int unsigned KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME_END = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WAIT_POLL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAUSE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PLAY      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STEP      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SLOW      = 3'd6;

  localparam logic [1:0] REG_FPS      = 2'd0;
  localparam logic [1:0] REG_MAX_SKIP = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [9:0]  FPS_RESET       = 10'd60;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd500;
  localparam logic [31:0] MS_PER_SEC      = 32'd1000;
  localparam logic [29:0] OVERRUN_FACTOR  = 30'd10;
  localparam logic [15:0] MIN_SLOW_PERIOD = 16'd2;

  localparam int unsigned DVD_W = 32;
  localparam int unsigned DSR_W = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_msec;
    logic        can_update;
    logic [15:0] slow_interval;
    logic [15:0] slow_duration;
  } in_t;

  typedef struct packed {
    logic               do_update;
    logic               do_render;
    logic [31:0]        wait_msec;
    logic signed [31:0] app_frames;
    logic signed [31:0] game_frames;
    logic [15:0]        updates_per_second;
    logic [15:0]        renders_per_second;
    logic               is_paused;
  } out_t;

  typedef enum logic [1:0] {
    DIV_MOD,
    DIV_FORMAL,
    DIV_DELTA
  } div_op_t;

  typedef struct packed {
    logic    latch_in;
    logic    div_start;
    div_op_t div_op;
    logic    exec_tick_a;
    logic    exec_tick_b;
    logic    exec_poll;
    logic    exec_simple;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       can_update;
    logic       need_mod;
    logic       div_done;
  } sts_t;

endpackage

@@ sv/fp_div.sv @@
// Restoring divider, one quotient bit per cycle.
module fp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fp_pkg::DVD_W-1:0]   dividend,
  input  logic [fp_pkg::DSR_W-1:0]   divisor,
  output logic                       done,
  output logic [fp_pkg::DVD_W-1:0]   quotient,
  output logic [fp_pkg::DSR_W-1:0]   remainder
);
  import fp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] q;
  logic [DSR_W-1:0] r;
  logic [DSR_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DSR_W:0]   trial;
  logic             fits;

  assign trial = {r, q[DVD_W-1]};
  assign fits  = (trial >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          r <= DSR_W'(trial - {1'b0, d});
        end else begin
          r <= trial[DSR_W-1:0];
        end
        q   <= {q[DVD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;
endmodule

@@ sv/fp_datapath.sv @@
// Pacer state, configuration registers, shared divider and result register.
module fp_datapath (
  input  logic          clk,
  input  logic          rst,
  input  fp_pkg::cmd_t  cmd,
  output fp_pkg::sts_t  sts,
  input  fp_pkg::in_t   in_data,
  output fp_pkg::out_t  out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [31:0]   cfg_wdata,
  output logic [31:0]   cfg_rdata
);
  import fp_pkg::*;

  logic [9:0]  fps;
  logic [7:0]  max_skip;
  logic [15:0] timeout;

  in_t         item;
  logic [31:0] next_deadline;
  logic [31:0] window_start;
  logic [15:0] update_count;
  logic [15:0] render_count;
  logic [15:0] upd_rate;
  logic [15:0] rend_rate;
  logic [7:0]  skip_run;
  logic [31:0] slow_timer;
  logic [15:0] slow_period;
  logic        paused_flag;
  logic        single_step;
  logic [31:0] app_counter;
  logic [31:0] game_counter;
  logic        upd_r;
  logic        rend_r;
  logic [31:0] wait_r;

  logic [9:0]        eff_fps;
  logic [DVD_W-1:0]  dvd;
  logic [DSR_W-1:0]  dsr;
  logic              div_done;
  logic [DVD_W-1:0]  quot;
  logic [DSR_W-1:0]  rem;
  logic [25:0]       uc_ms;
  logic              adv;
  logic [31:0]       diff;
  logic signed [33:0] actual;
  logic signed [33:0] formal;
  logic signed [33:0] limit;
  logic [29:0]       lim30;
  logic              render;
  logic [31:0]       delta;

  assign eff_fps = (fps == 10'd0) ? 10'd1 : fps;
  assign uc_ms   = 26'(update_count) * 26'(MS_PER_SEC);

  always_comb begin
    case (cmd.div_op)
      DIV_MOD: begin
        dvd = slow_timer;
        dsr = slow_period;
      end
      DIV_FORMAL: begin
        dvd = 32'(uc_ms);
        dsr = 16'(eff_fps);
      end
      default: begin
        dvd = MS_PER_SEC;
        dsr = 16'(eff_fps);
      end
    endcase
  end

  fp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dsr),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // slow motion: advance only when the timer is a multiple of the period
  assign adv = !paused_flag && ((slow_timer == 32'd0) || (rem == '0));

  assign diff   = item.now_msec - window_start;
  assign actual = {{2{diff[31]}}, diff};
  assign formal = {8'd0, quot[25:0]};
  assign lim30  = 30'(quot[25:0]) * OVERRUN_FACTOR;
  assign limit  = {4'd0, lim30};
  assign render = (actual <= formal) || (actual >= limit) || (skip_run >= max_skip);
  assign delta  = 32'(quot[9:0]);

  assign sts.kind       = item.kind;
  assign sts.can_update = item.can_update;
  assign sts.need_mod   = !paused_flag && (slow_timer != 32'd0);
  assign sts.div_done   = div_done;

  always_comb begin
    case (cfg_idx)
      REG_FPS:      cfg_rdata = 32'(fps);
      REG_MAX_SKIP: cfg_rdata = 32'(max_skip);
      REG_TIMEOUT:  cfg_rdata = 32'(timeout);
      default:      cfg_rdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fps           <= FPS_RESET;
      max_skip      <= 8'd0;
      timeout       <= TIMEOUT_RESET;
      next_deadline <= 32'd0;
      window_start  <= 32'd0;
      update_count  <= 16'd0;
      render_count  <= 16'd0;
      upd_rate      <= 16'd0;
      rend_rate     <= 16'd0;
      skip_run      <= 8'd0;
      slow_timer    <= 32'd0;
      slow_period   <= MIN_SLOW_PERIOD;
      paused_flag   <= 1'b0;
      single_step   <= 1'b0;
      app_counter   <= '1;
      game_counter  <= '1;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_FPS: begin
            fps           <= cfg_wdata[9:0];
            next_deadline <= 32'd0;
          end
          REG_MAX_SKIP: max_skip <= cfg_wdata[7:0];
          REG_TIMEOUT:  timeout  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.latch_in) begin
        item   <= in_data;
        upd_r  <= 1'b0;
        rend_r <= 1'b0;
        wait_r <= 32'd0;
      end
      if (cmd.exec_tick_a) begin
        app_counter <= app_counter + 32'd1;
        if (sts.need_mod) begin
          slow_timer <= slow_timer - 32'd1;
        end
        if (adv) begin
          game_counter <= game_counter + 32'd1;
          if (single_step) begin
            single_step <= 1'b0;
            paused_flag <= 1'b1;
          end
          if (update_count != 16'hFFFF) begin
            update_count <= update_count + 16'd1;
          end
        end
        upd_r <= adv;
      end
      if (cmd.exec_tick_b) begin
        rend_r <= render;
        if (render) begin
          skip_run <= 8'd0;
          if (render_count != 16'hFFFF) begin
            render_count <= render_count + 16'd1;
          end
        end else begin
          skip_run <= skip_run + 8'd1;
        end
      end
      if (cmd.exec_poll) begin
        if ((item.now_msec + 32'(timeout) < next_deadline) ||
            (next_deadline + delta < item.now_msec)) begin
          next_deadline <= item.now_msec + delta;
        end else if (next_deadline <= item.now_msec) begin
          next_deadline <= next_deadline + delta;
        end else begin
          wait_r <= next_deadline - item.now_msec;
        end
      end
      if (cmd.exec_simple) begin
        case (item.kind)
          KIND_FRAME_END: begin
            if (item.now_msec >= window_start + MS_PER_SEC) begin
              window_start <= item.now_msec;
              upd_rate     <= update_count;
              rend_rate    <= render_count;
              update_count <= 16'd0;
              render_count <= 16'd0;
            end
          end
          KIND_PAUSE: begin
            single_step <= 1'b0;
            paused_flag <= 1'b1;
          end
          KIND_PLAY: begin
            single_step <= 1'b0;
            paused_flag <= 1'b0;
          end
          KIND_STEP: begin
            single_step <= paused_flag;
            paused_flag <= !paused_flag;
          end
          KIND_SLOW: begin
            if (item.slow_duration != 16'd0) begin
              slow_timer <= item.slow_duration * slow_period;
            end
            if (item.slow_interval >= MIN_SLOW_PERIOD) begin
              slow_period <= item.slow_interval;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.do_update          <= upd_r;
      out_data.do_render          <= rend_r;
      out_data.wait_msec          <= wait_r;
      out_data.app_frames         <= $signed(app_counter);
      out_data.game_frames        <= $signed(game_counter);
      out_data.updates_per_second <= upd_rate;
      out_data.renders_per_second <= rend_rate;
      out_data.is_paused          <= paused_flag;
    end
  end
endmodule

@@ sv/fp_ctrl.sv @@
// Sequencer for the frame pacer: steps each request through the datapath.
module fp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  fp_pkg::sts_t  sts,
  output fp_pkg::cmd_t  cmd
);
  import fp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MOD_WAIT,
    ST_TICK_A,
    ST_FRM_GO,
    ST_FRM_WAIT,
    ST_TICK_B,
    ST_DLT_WAIT,
    ST_POLL,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;
  logic   can_load;

  assign in_stall = (state != ST_IDLE);
  assign take     = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.div_op = DIV_DELTA;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.kind == KIND_TICK && sts.can_update) begin
          if (sts.need_mod) begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_MOD;
            state_next    = ST_MOD_WAIT;
          end else begin
            state_next = ST_TICK_A;
          end
        end else if (sts.kind == KIND_WAIT_POLL) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_DELTA;
          state_next    = ST_DLT_WAIT;
        end else begin
          cmd.exec_simple = (sts.kind != KIND_TICK);
          state_next      = ST_DONE;
        end
      end
      ST_MOD_WAIT: begin
        cmd.div_op = DIV_MOD;
        if (sts.div_done) begin
          state_next = ST_TICK_A;
        end
      end
      ST_TICK_A: begin
        cmd.div_op      = DIV_MOD;
        cmd.exec_tick_a = 1'b1;
        state_next      = ST_FRM_GO;
      end
      ST_FRM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_FORMAL;
        state_next    = ST_FRM_WAIT;
      end
      ST_FRM_WAIT: begin
        cmd.div_op = DIV_FORMAL;
        if (sts.div_done) begin
          state_next = ST_TICK_B;
        end
      end
      ST_TICK_B: begin
        cmd.div_op      = DIV_FORMAL;
        cmd.exec_tick_b = 1'b1;
        state_next      = ST_DONE;
      end
      ST_DLT_WAIT: begin
        if (sts.div_done) begin
          state_next = ST_POLL;
        end
      end
      ST_POLL: begin
        cmd.exec_poll = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_take_dispatch: assert property (@(posedge clk) disable iff (rst)
    take |=> state == ST_DISPATCH)
    else $error("accepted request did not reach dispatch");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == ST_MOD_WAIT || state == ST_FRM_WAIT ||
                      state == ST_DLT_WAIT))
    else $error("divider finished outside a wait state");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> state == ST_DONE)
    else $error("pending result overwritten");
endmodule

@@ sv/frame_pacer_with_skip_and_slow_motion.sv @@
// Frame pacer with frame skip and slow motion: top level.
// One request is worked at a time; the next one is taken while the last
// result waits at the output. A tick that may update runs a modulo when
// slow motion is running, then the formal-time division; a wait poll runs
// 1000 / frame rate; other kinds need no division. Divisions use the shared
// 32-step restoring divider. Registers sit at byte addresses 0, 4 and 8;
// the user must write them only while the block is idle (not enforced).
module frame_pacer_with_skip_and_slow_motion (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  fp_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fp_pkg::out_t  out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import fp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  fp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (paddr[3:2]),
    .cfg_wdata (pwdata),
    .cfg_rdata (prdata)
  );
endmodule
